// ===== rtl/hrlg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlg_pkg
// Shared types, constants and helper functions of the haversine range and
// link grade core.
// ----------------------------------------------------------------------------
package hrlg_pkg;

   // field widths
   localparam int LAT_W     = 28;
   localparam int LON_W     = 29;
   localparam int DBM_W     = 9;
   localparam int DIST_W    = 31;
   localparam int GRADE_W   = 2;
   localparam int CSR_W     = 29;
   localparam int CSR_IDX_W = 2;

   // CORDIC iteration count (12..32)
   localparam int CORDIC_STEPS = 24;
   localparam int SQ_STEPS     = 31;
   localparam int CNT_W        = 6;
   localparam int LANES        = 4;

   // datapath widths
   localparam int ANG_W = 32;   // Q2.30 angle
   localparam int CW    = 34;   // CORDIC / product word
   localparam int A_W   = 31;   // clamped a, 0..2^30
   localparam int SQ_VW = 61;   // sqrt radicand
   localparam int SQ_RW = 62;   // sqrt root accumulator
   localparam int PROD_W = 62;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_LAT = 2'd0,
      CSR_REF_LON = 2'd1,
      CSR_STRONG  = 2'd2,
      CSR_GOOD    = 2'd3
   } csr_index_type;

   localparam logic [GRADE_W-1:0] GRADE_STRONG = 2'd0;
   localparam logic [GRADE_W-1:0] GRADE_GOOD   = 2'd1;
   localparam logic [GRADE_W-1:0] GRADE_WEAK   = 2'd2;

   localparam logic signed [LAT_W-1:0] REF_LAT_RESET = 28'sd11000000;
   localparam logic signed [LON_W-1:0] REF_LON_RESET = 29'sd77000000;
   localparam logic signed [DBM_W-1:0] STRONG_RESET  = -9'sd60;
   localparam logic signed [DBM_W-1:0] GOOD_RESET    = -9'sd90;

   localparam logic signed [31:0] DEG_HALF    = 32'sd180000000;
   localparam logic signed [31:0] DEG_FULL    = 32'sd360000000;
   localparam logic [LAT_W-1:0]   DEG_HALF_U  = 28'd180000000;
   localparam logic [LAT_W-1:0]   DEG_QUARTER = 28'd90000000;
   localparam logic [22:0]        RAD_MUL     = 23'd4912665;

   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sh026DD3B6A;
   localparam logic [A_W-1:0]       ONE_Q30  = 31'h4000_0000;
   localparam logic [SQ_VW-1:0]     SQ_TOP   = {1'b1, 60'd0};
   localparam logic [30:0]          TWICE_RADIUS_CM = 31'd1274200000;
   localparam logic [PROD_W:0]      ROUND_HALF = 63'h2000_0000;
   localparam logic [DIST_W-1:0]    DIST_MAX = 31'd2001600000;

   // one queue entry: everything the back end needs for one request
   typedef struct packed {
      logic signed [ANG_W-1:0] ang_dlat;
      logic signed [ANG_W-1:0] ang_dlon;
      logic signed [ANG_W-1:0] ang_ref;
      logic signed [ANG_W-1:0] ang_rem;
      logic                    neg_ref;
      logic                    neg_rem;
      logic [GRADE_W-1:0]      grade;
   } work_type;

   typedef struct packed {
      logic               empty;
      logic [FIFO_CW-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic [SQ_VW-1:0] v;
      logic [SQ_RW-1:0] r;
   } sqrt_type;

   function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CW-1:0] val;
      case (idx)
         5'd0:  val = 34'sh03243F6A8;
         5'd1:  val = 34'sh01DAC6705;
         5'd2:  val = 34'sh00FADBAFC;
         5'd3:  val = 34'sh007F56EA6;
         5'd4:  val = 34'sh003FEAB76;
         5'd5:  val = 34'sh001FFD55B;
         5'd6:  val = 34'sh000FFFAAA;
         5'd7:  val = 34'sh0007FFF55;
         5'd8:  val = 34'sh0003FFFEA;
         5'd9:  val = 34'sh0001FFFFD;
         5'd10: val = 34'sh0000FFFFF;
         5'd11: val = 34'sh00007FFFF;
         5'd12: val = 34'sh00003FFFF;
         5'd13: val = 34'sh00001FFFF;
         5'd14: val = 34'sh00000FFFF;
         5'd15: val = 34'sh000007FFF;
         5'd16: val = 34'sh000003FFF;
         5'd17: val = 34'sh000001FFF;
         5'd18: val = 34'sh000000FFF;
         5'd19: val = 34'sh0000007FF;
         5'd20: val = 34'sh0000003FF;
         5'd21: val = 34'sh0000001FF;
         5'd22: val = 34'sh0000000FF;
         5'd23: val = 34'sh00000007F;
         5'd24: val = 34'sh00000003F;
         5'd25: val = 34'sh00000001F;
         5'd26: val = 34'sh00000000F;
         5'd27: val = 34'sh000000008;
         5'd28: val = 34'sh000000004;
         5'd29: val = 34'sh000000002;
         5'd30: val = 34'sh000000001;
         default: val = '0;
      endcase
      return val;
   endfunction

   // Q30 * Q30 -> Q30, floor
   function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
      logic signed [2*CW-1:0] p;
      p = a * b;
      return p[CW+29:30];
   endfunction

   // one digit of the restoring square root
   function automatic sqrt_type sqrt_step(input logic [SQ_VW-1:0] v,
                                          input logic [SQ_RW-1:0] r,
                                          input logic [SQ_VW-1:0] sq_bit);
      sqrt_type   res;
      logic [SQ_RW-1:0] trial;
      trial = r + {1'b0, sq_bit};
      if ({1'b0, v} >= trial) begin
         res.v = v - trial[SQ_VW-1:0];
         res.r = (r >> 1) + {1'b0, sq_bit};
      end else begin
         res.v = v;
         res.r = r >> 1;
      end
      return res;
   endfunction

endpackage

// ===== rtl/hrlg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlg_front
// Control registers and a three stage intake pipe: coordinate differences,
// angle wrap and latitude fold, radian conversion. Grades the signal.
// ----------------------------------------------------------------------------
module hrlg_front import hrlg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic signed [LAT_W-1:0]    req_remote_latitude,
   input  logic signed [LON_W-1:0]    req_remote_longitude,
   input  logic signed [DBM_W-1:0]    req_signal_dbm,
   input  queue_status_type           queue_status,
   output logic                       push_valid,
   output work_type                   push_data
);

   logic signed [LAT_W-1:0] ref_lat_ff, ref_lat_in;
   logic signed [LON_W-1:0] ref_lon_ff, ref_lon_in;
   logic signed [DBM_W-1:0] strong_ff, strong_in;
   logic signed [DBM_W-1:0] good_ff, good_in;

   // stage 1
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [29:0]      s1_dlat_ff, s1_dlat_in;
   logic signed [30:0]      s1_dlon_ff, s1_dlon_in;
   logic [LAT_W-1:0]        s1_aref_ff, s1_aref_in;
   logic [LAT_W-1:0]        s1_arem_ff, s1_arem_in;
   logic [GRADE_W-1:0]      s1_grade_ff, s1_grade_in;
   // stage 2
   logic                    s2_valid_ff, s2_valid_in;
   logic signed [28:0]      s2_dlat_ff, s2_dlat_in;
   logic signed [28:0]      s2_dlon_ff, s2_dlon_in;
   logic [26:0]             s2_wref_ff, s2_wref_in;
   logic [26:0]             s2_wrem_ff, s2_wrem_in;
   logic                    s2_nref_ff, s2_nref_in;
   logic                    s2_nrem_ff, s2_nrem_in;
   logic [GRADE_W-1:0]      s2_grade_ff, s2_grade_in;
   // stage 3
   logic                    s3_valid_ff, s3_valid_in;
   work_type                s3_work_ff, s3_work_in;

   logic                    accept;
   logic [FIFO_CW-1:0]      occupancy;
   logic signed [31:0]      dlat32, dlon32;
   logic signed [52:0]      p_dlat, p_dlon;
   logic [49:0]             p_ref, p_rem;

   // queue slots promised to requests still in the pipe
   assign occupancy = queue_status.count + FIFO_CW'(s1_valid_ff) + FIFO_CW'(s2_valid_ff)
                      + FIFO_CW'(s3_valid_ff);
   assign req_full  = occupancy >= FIFO_CW'(FIFO_DEPTH);
   assign accept    = req_push && !req_full;

   always_comb begin
      ref_lat_in = ref_lat_ff;
      ref_lon_in = ref_lon_ff;
      strong_in  = strong_ff;
      good_in    = good_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_REF_LAT: ref_lat_in = csr_wdata[LAT_W-1:0];
            CSR_REF_LON: ref_lon_in = csr_wdata[LON_W-1:0];
            CSR_STRONG:  strong_in  = csr_wdata[DBM_W-1:0];
            CSR_GOOD:    good_in    = csr_wdata[DBM_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: differences, magnitudes, grade
   always_comb begin
      s1_valid_in = accept;
      s1_dlat_in  = 30'(req_remote_latitude) - 30'(ref_lat_ff);
      s1_dlon_in  = 31'(req_remote_longitude) - 31'(ref_lon_ff);
      s1_aref_in  = ref_lat_ff[LAT_W-1] ? LAT_W'(-ref_lat_ff) : LAT_W'(ref_lat_ff);
      s1_arem_in  = req_remote_latitude[LAT_W-1] ? LAT_W'(-req_remote_latitude)
                                                 : LAT_W'(req_remote_latitude);
      if (req_signal_dbm > strong_ff) begin
         s1_grade_in = GRADE_STRONG;
      end else if (req_signal_dbm > good_ff) begin
         s1_grade_in = GRADE_GOOD;
      end else begin
         s1_grade_in = GRADE_WEAK;
      end
   end

   // stage 2: wrap into [-180, 180) degrees, fold latitudes past 90
   always_comb begin
      dlat32 = {{2{s1_dlat_ff[29]}}, s1_dlat_ff};
      dlon32 = {s1_dlon_ff[30], s1_dlon_ff};
      s2_valid_in = s1_valid_ff;
      if (dlat32 < -DEG_HALF) begin
         s2_dlat_in = 29'(dlat32 + DEG_FULL);
      end else if (dlat32 >= DEG_HALF) begin
         s2_dlat_in = 29'(dlat32 - DEG_FULL);
      end else begin
         s2_dlat_in = 29'(dlat32);
      end
      if (dlon32 < -DEG_HALF) begin
         s2_dlon_in = 29'(dlon32 + DEG_FULL);
      end else if (dlon32 >= DEG_HALF) begin
         s2_dlon_in = 29'(dlon32 - DEG_FULL);
      end else begin
         s2_dlon_in = 29'(dlon32);
      end
      s2_nref_in = s1_aref_ff > DEG_QUARTER;
      s2_wref_in = s2_nref_in ? 27'(DEG_HALF_U - s1_aref_ff) : 27'(s1_aref_ff);
      s2_nrem_in = s1_arem_ff > DEG_QUARTER;
      s2_wrem_in = s2_nrem_in ? 27'(DEG_HALF_U - s1_arem_ff) : 27'(s1_arem_ff);
      s2_grade_in = s1_grade_ff;
   end

   // stage 3: microdegrees to Q2.30 radians (half angles for the differences)
   always_comb begin
      p_dlat = s2_dlat_ff * $signed({1'b0, RAD_MUL});
      p_dlon = s2_dlon_ff * $signed({1'b0, RAD_MUL});
      p_ref  = s2_wref_ff * RAD_MUL;
      p_rem  = s2_wrem_ff * RAD_MUL;
      s3_valid_in         = s2_valid_ff;
      s3_work_in.ang_dlat = p_dlat[50:19];
      s3_work_in.ang_dlon = p_dlon[50:19];
      s3_work_in.ang_ref  = p_ref[49:18];
      s3_work_in.ang_rem  = p_rem[49:18];
      s3_work_in.neg_ref  = s2_nref_ff;
      s3_work_in.neg_rem  = s2_nrem_ff;
      s3_work_in.grade    = s2_grade_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lat_ff  <= REF_LAT_RESET;
         ref_lon_ff  <= REF_LON_RESET;
         strong_ff   <= STRONG_RESET;
         good_ff     <= GOOD_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         ref_lat_ff  <= ref_lat_in;
         ref_lon_ff  <= ref_lon_in;
         strong_ff   <= strong_in;
         good_ff     <= good_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dlat_ff  <= s1_dlat_in;
      s1_dlon_ff  <= s1_dlon_in;
      s1_aref_ff  <= s1_aref_in;
      s1_arem_ff  <= s1_arem_in;
      s1_grade_ff <= s1_grade_in;
      s2_dlat_ff  <= s2_dlat_in;
      s2_dlon_ff  <= s2_dlon_in;
      s2_wref_ff  <= s2_wref_in;
      s2_wrem_ff  <= s2_wrem_in;
      s2_nref_ff  <= s2_nref_in;
      s2_nrem_ff  <= s2_nrem_in;
      s2_grade_ff <= s2_grade_in;
      s3_work_ff  <= s3_work_in;
   end

   assign push_valid = s3_valid_ff;
   assign push_data  = s3_work_ff;

endmodule

// ===== rtl/hrlg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlg_queue
// Small register queue between the intake pipe and the solver.
// ----------------------------------------------------------------------------
module hrlg_queue import hrlg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  work_type         push_data,
   input  logic             pop,
   output work_type         pop_data,
   output queue_status_type status
);

   work_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + FIFO_CW'(push) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.empty = count_ff == '0;
   assign status.count = count_ff;

endmodule

// ===== rtl/hrlg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlg_back
// Solver: four CORDIC lanes for the sines and cosines, Q30 products, two
// digit-serial square roots, CORDIC atan2 on lane 0, scaling to centimeters
// and the result register.
// ----------------------------------------------------------------------------
module hrlg_back import hrlg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  queue_status_type    queue_status,
   input  work_type            queue_data,
   output logic                queue_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic [DIST_W-1:0]   rsp_distance_cm,
   output logic [GRADE_W-1:0]  rsp_link_grade
);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_ROT    = 12'b0000_0000_0010,
      ST_MUL1   = 12'b0000_0000_0100,
      ST_MUL2   = 12'b0000_0000_1000,
      ST_MUL3   = 12'b0000_0001_0000,
      ST_SUM    = 12'b0000_0010_0000,
      ST_SQINIT = 12'b0000_0100_0000,
      ST_SQRT   = 12'b0000_1000_0000,
      ST_ATINIT = 12'b0001_0000_0000,
      ST_ATAN   = 12'b0010_0000_0000,
      ST_SCALE  = 12'b0100_0000_0000,
      ST_ROUND  = 12'b1000_0000_0000
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    vec_ff, vec_in;
   logic                    neg_ref_ff, neg_ref_in;
   logic                    neg_rem_ff, neg_rem_in;
   logic [GRADE_W-1:0]      grade_ff, grade_in;
   logic signed [CW-1:0]    x_ff [LANES], x_in [LANES];
   logic signed [CW-1:0]    y_ff [LANES], y_in [LANES];
   logic signed [CW-1:0]    z_ff [LANES], z_in [LANES];
   logic signed [CW-1:0]    sqlat_ff, sqlat_in;
   logic signed [CW-1:0]    sqlon_ff, sqlon_in;
   logic signed [CW-1:0]    cosr_ff, cosr_in;
   logic signed [CW-1:0]    cosm_ff, cosm_in;
   logic signed [CW-1:0]    cc_ff, cc_in;
   logic signed [CW-1:0]    t3_ff, t3_in;
   logic [A_W-1:0]          a_ff, a_in;
   logic [SQ_VW-1:0]        va_ff, va_in, vb_ff, vb_in;
   logic [SQ_RW-1:0]        ra_ff, ra_in, rb_ff, rb_in;
   logic [SQ_VW-1:0]        sq_bit_ff, sq_bit_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    out_valid_ff, out_valid_in;
   logic [DIST_W-1:0]       out_dist_ff, out_dist_in;
   logic [GRADE_W-1:0]      out_grade_ff, out_grade_in;

   logic signed [CW-1:0]    x_step [LANES], y_step [LANES], z_step [LANES];
   logic signed [CW-1:0]    xs, ys, at;
   logic                    sigma;
   sqrt_type                sq_a, sq_b;
   logic signed [CW:0]      a_sum;
   logic [30:0]             c_pos;
   logic [PROD_W:0]         rounded;
   logic [DIST_W+1:0]       dist_raw;

   // one CORDIC iteration on every lane; rotation steers by z, vectoring by y
   always_comb begin
      xs = '0;
      ys = '0;
      sigma = 1'b0;
      at = atan_q30(cnt_ff[4:0]);
      for (int k = 0; k < LANES; k++) begin
         xs = x_ff[k] >>> cnt_ff[4:0];
         ys = y_ff[k] >>> cnt_ff[4:0];
         sigma = vec_ff ? y_ff[k][CW-1] : !z_ff[k][CW-1];
         if (sigma) begin
            x_step[k] = x_ff[k] - ys;
            y_step[k] = y_ff[k] + xs;
            z_step[k] = z_ff[k] - at;
         end else begin
            x_step[k] = x_ff[k] + ys;
            y_step[k] = y_ff[k] - xs;
            z_step[k] = z_ff[k] + at;
         end
      end
   end

   assign sq_a     = sqrt_step(va_ff, ra_ff, sq_bit_ff);
   assign sq_b     = sqrt_step(vb_ff, rb_ff, sq_bit_ff);
   assign a_sum    = {sqlat_ff[CW-1], sqlat_ff} + {t3_ff[CW-1], t3_ff};
   assign c_pos    = z_ff[0][CW-1] ? '0 : z_ff[0][30:0];
   assign rounded  = {1'b0, prod_ff} + ROUND_HALF;
   assign dist_raw = rounded[PROD_W:30];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      vec_in       = vec_ff;
      neg_ref_in   = neg_ref_ff;
      neg_rem_in   = neg_rem_ff;
      grade_in     = grade_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      sqlat_in     = sqlat_ff;
      sqlon_in     = sqlon_ff;
      cosr_in      = cosr_ff;
      cosm_in      = cosm_ff;
      cc_in        = cc_ff;
      t3_in        = t3_ff;
      a_in         = a_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      sq_bit_in    = sq_bit_ff;
      prod_in      = prod_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_dist_in  = out_dist_ff;
      out_grade_in = out_grade_ff;
      queue_pop    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               queue_pop = 1'b1;
               for (int k = 0; k < LANES; k++) begin
                  x_in[k] = GAIN_Q30;
                  y_in[k] = '0;
               end
               z_in[0]    = CW'(queue_data.ang_dlat);
               z_in[1]    = CW'(queue_data.ang_dlon);
               z_in[2]    = CW'(queue_data.ang_ref);
               z_in[3]    = CW'(queue_data.ang_rem);
               neg_ref_in = queue_data.neg_ref;
               neg_rem_in = queue_data.neg_rem;
               grade_in   = queue_data.grade;
               vec_in     = 1'b0;
               cnt_in     = '0;
               state_in   = ST_ROT;
            end
         end
         ST_ROT, ST_ATAN: begin
            x_in   = x_step;
            y_in   = y_step;
            z_in   = z_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = (state_ff == ST_ROT) ? ST_MUL1 : ST_SCALE;
            end
         end
         ST_MUL1: begin
            sqlat_in = mul_q30(y_ff[0], y_ff[0]);
            sqlon_in = mul_q30(y_ff[1], y_ff[1]);
            cosr_in  = neg_ref_ff ? -x_ff[2] : x_ff[2];
            cosm_in  = neg_rem_ff ? -x_ff[3] : x_ff[3];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cc_in    = mul_q30(cosr_ff, cosm_ff);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            t3_in    = mul_q30(cc_ff, sqlon_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (a_sum[CW]) begin
               a_in = '0;
            end else if (a_sum > (CW+1)'(ONE_Q30)) begin
               a_in = ONE_Q30;
            end else begin
               a_in = a_sum[A_W-1:0];
            end
            state_in = ST_SQINIT;
         end
         ST_SQINIT: begin
            va_in     = {a_ff, 30'd0};
            vb_in     = {A_W'(ONE_Q30 - a_ff), 30'd0};
            ra_in     = '0;
            rb_in     = '0;
            sq_bit_in = SQ_TOP;
            cnt_in    = '0;
            state_in  = ST_SQRT;
         end
         ST_SQRT: begin
            va_in     = sq_a.v;
            ra_in     = sq_a.r;
            vb_in     = sq_b.v;
            rb_in     = sq_b.r;
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQ_STEPS - 1)) begin
               state_in = ST_ATINIT;
            end
         end
         ST_ATINIT: begin
            x_in[0]  = CW'(rb_ff[30:0]);
            y_in[0]  = CW'(ra_ff[30:0]);
            z_in[0]  = '0;
            vec_in   = 1'b1;
            cnt_in   = '0;
            state_in = ST_ATAN;
         end
         ST_SCALE: begin
            prod_in  = c_pos * TWICE_RADIUS_CM;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            // hold here while the previous result is still unread
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_dist_in  = (dist_raw > (DIST_W+2)'(DIST_MAX)) ? DIST_MAX
                                                                 : dist_raw[DIST_W-1:0];
               out_grade_in = grade_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      vec_ff       <= vec_in;
      neg_ref_ff   <= neg_ref_in;
      neg_rem_ff   <= neg_rem_in;
      grade_ff     <= grade_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      sqlat_ff     <= sqlat_in;
      sqlon_ff     <= sqlon_in;
      cosr_ff      <= cosr_in;
      cosm_ff      <= cosm_in;
      cc_ff        <= cc_in;
      t3_ff        <= t3_in;
      a_ff         <= a_in;
      va_ff        <= va_in;
      vb_ff        <= vb_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      sq_bit_ff    <= sq_bit_in;
      prod_ff      <= prod_in;
      out_dist_ff  <= out_dist_in;
      out_grade_ff <= out_grade_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_distance_cm = out_dist_ff;
   assign rsp_link_grade  = out_grade_ff;

endmodule

// ===== rtl/haversine_range_and_link_grade_core.sv =====
`timescale 1ns / 1ps
// The solver takes one request at a time from the queue and runs its sequence:
// 24-step CORDIC pass, four Q30 products, 31-digit square roots, 24-step CORDIC
// atan2, scaling and rounding. Requests are taken every cycle until the queue
// entries plus the requests in the intake pipe reach the 4-entry queue depth.
// Reset (synchronous, active high) empties pipe, queue and result register and
// restores the csr defaults.
// ----------------------------------------------------------------------------
// haversine_range_and_link_grade_core
// Great-circle distance from a reference position in centimeters, plus a
// three-level signal grade, behind queue-style request and response ports.
// ----------------------------------------------------------------------------
module haversine_range_and_link_grade_core import hrlg_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic signed [LAT_W-1:0]   req_remote_latitude,
   input  logic signed [LON_W-1:0]   req_remote_longitude,
   input  logic signed [DBM_W-1:0]   req_signal_dbm,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [DIST_W-1:0]         rsp_distance_cm,
   output logic [GRADE_W-1:0]        rsp_link_grade
);

   queue_status_type queue_status;
   logic             push_valid;
   work_type         push_data;
   logic             queue_pop;
   work_type         queue_data;

   hrlg_front u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_remote_latitude  (req_remote_latitude),
      .req_remote_longitude (req_remote_longitude),
      .req_signal_dbm       (req_signal_dbm),
      .queue_status         (queue_status),
      .push_valid           (push_valid),
      .push_data            (push_data)
   );

   hrlg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .status    (queue_status)
   );

   hrlg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (queue_status),
      .queue_data      (queue_data),
      .queue_pop       (queue_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_distance_cm (rsp_distance_cm),
      .rsp_link_grade  (rsp_link_grade)
   );

endmodule

// ===== rtl/hrlg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlg_checker
// Port-level checks of the core, attached by bind.
// ----------------------------------------------------------------------------
module hrlg_checker import hrlg_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_full,
   input logic                      rsp_empty,
   input logic                      rsp_pop,
   input logic [DIST_W-1:0]         rsp_distance_cm,
   input logic [GRADE_W-1:0]        rsp_link_grade
);

   // after reset nothing is pending and intake is open
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) && !reset |-> rsp_empty && !req_full)
      else $error("core not clear after reset");

   // an unread result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_distance_cm)
                                 && $stable(rsp_link_grade))
      else $error("response changed before pop");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_distance_cm <= DIST_MAX)
      else $error("distance above saturation limit");

   a_grade_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_link_grade == GRADE_STRONG || rsp_link_grade == GRADE_GOOD
                     || rsp_link_grade == GRADE_WEAK)
      else $error("undefined link grade");

endmodule

bind haversine_range_and_link_grade_core hrlg_checker u_checker (.*);
